>>> rtl/http_packet_classifier_core_macros.svh
// Assertion macros shared by the classifier RTL.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef HTTP_PACKET_CLASSIFIER_CORE_MACROS_SVH
`define HTTP_PACKET_CLASSIFIER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define HPC_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("classifier check failed");
`define HPC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("classifier check failed");
`else
`define HPC_ASSERT(label, cond)
`define HPC_ASSERT_NEXT(label, trig, cond)
`endif
`endif

>>> rtl/hpc_pkg.sv
`timescale 1ns / 1ps
package hpc_pkg;

    typedef enum logic [2:0] {
        VERDICT_REQUEST    = 3'd0,
        VERDICT_RESPONSE   = 3'd1,
        VERDICT_NOT_HTTP   = 3'd2,
        VERDICT_BAD_IP_LEN = 3'd3,
        VERDICT_BAD_TCP_LEN = 3'd4,
        VERDICT_NO_PAYLOAD = 3'd5,
        VERDICT_TRUNCATED  = 3'd6
    } verdict_t;

    // The first member sits in the highest bits, so verdict ends up at bit 0.
    typedef struct packed {
        logic [15:0] payload_length;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        logic [15:0] http_number;
        verdict_t    verdict;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
    localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;
    localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
    localparam logic [7:0]  PRINT_LOW     = 8'h20;
    localparam logic [7:0]  PRINT_HIGH    = 8'h7E;
    localparam logic [7:0]  SPACE_CHAR    = 8'h20;

    // Letters of "HTTP".
    function automatic logic [7:0] tag_byte(input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = 8'h48;
            2'd1:    c = 8'h54;
            2'd2:    c = 8'h54;
            2'd3:    c = 8'h50;
            default: c = 8'h48;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/hpc_front.sv
`timescale 1ns / 1ps
`include "http_packet_classifier_core_macros.svh"
module hpc_front
    import hpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        push_valid,
    input  logic        push_ready,
    output result_t     push_data
);

    logic [15:0] byte_offset_reg;
    logic [3:0]  ihl_reg;
    logic [3:0]  thw_reg;
    logic [15:0] total_reg;
    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [15:0] src_port_reg;
    logic [15:0] dst_port_reg;
    logic [2:0]  mp_reg;
    logic [1:0]  sc_reg;
    logic        done_reg;
    verdict_t    pend_reg;
    logic        alive_reg;
    logic [15:0] counter_reg;
    logic [7:0]  ps_reg;
    logic [15:0] plen_reg;

    logic        take;
    logic [15:0] o;
    logic        live;
    logic        ihl_hit;
    logic [3:0]  ihl_next;
    logic        ihl_ok;
    logic [6:0]  ts;
    logic        tcp_zone;
    logic        thw_hit;
    logic [3:0]  thw_next;
    logic        thw_ok;
    logic [15:0] total_next;
    logic [31:0] src_addr_next;
    logic [31:0] dst_addr_next;
    logic [15:0] src_port_next;
    logic [15:0] dst_port_next;
    logic [6:0]  hdrs;
    logic [15:0] plen_next;
    logic [7:0]  ps_next;
    logic [15:0] idx;
    logic        in_pay;
    logic        idx_last;
    logic [2:0]  mp_m1;
    logic [2:0]  mp_next;
    logic [1:0]  sc_next;
    logic        done_next;
    verdict_t    pend_next;
    logic        alive_next;
    logic        scan_stop;
    logic        scan_consumed;
    logic [3:0]  ihl_eff;
    logic [6:0]  ts_eff;
    verdict_t    verdict;
    logic [15:0] plen_out;

    assign in_ready   = push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = take && in_last;

    assign o    = byte_offset_reg;
    assign live = (o != OFFSET_MAX);

    // Header fields.
    assign ihl_hit  = live && (o == ETH_HDR_BYTES);
    assign ihl_next = ihl_hit ? in_byte[3:0] : ihl_reg;
    assign ihl_ok   = (ihl_reg >= MIN_HDR_WORDS);
    assign ts       = 7'd14 + {1'b0, ihl_reg, 2'b00};
    assign tcp_zone = live && (o > ETH_HDR_BYTES) && ihl_ok;
    assign thw_hit  = tcp_zone && (o == {9'd0, ts + 7'd12});
    assign thw_next = thw_hit ? in_byte[7:4] : thw_reg;
    assign thw_ok   = (thw_reg >= MIN_HDR_WORDS);

    always_comb
    begin
        total_next = total_reg;
        if (live && o == 16'd16)
            total_next = {in_byte, total_reg[7:0]};
        else if (live && o == 16'd17)
            total_next = {total_reg[15:8], in_byte};
    end

    assign src_addr_next = (live && o >= 16'd26 && o <= 16'd29) ?
                           {src_addr_reg[23:0], in_byte} : src_addr_reg;
    assign dst_addr_next = (live && o >= 16'd30 && o <= 16'd33) ?
                           {dst_addr_reg[23:0], in_byte} : dst_addr_reg;
    assign src_port_next = (tcp_zone && (o == {9'd0, ts} || o == {9'd0, ts + 7'd1})) ?
                           {src_port_reg[7:0], in_byte} : src_port_reg;
    assign dst_port_next = (tcp_zone && (o == {9'd0, ts + 7'd2} || o == {9'd0, ts + 7'd3})) ?
                           {dst_port_reg[7:0], in_byte} : dst_port_reg;

    // Payload bounds follow the TCP length byte in the same cycle, so they are
    // already registered when the first payload byte arrives.
    assign hdrs      = {1'b0, ihl_reg, 2'b00} + {1'b0, thw_next, 2'b00};
    assign plen_next = (total_reg > {9'd0, hdrs}) ? (total_reg - {9'd0, hdrs}) : 16'd0;
    assign ps_next   = {1'b0, ts} + {2'b00, thw_next, 2'b00};

    assign idx      = o - {8'd0, ps_reg};
    assign in_pay   = tcp_zone && thw_ok && (o >= {8'd0, ps_reg}) && (idx < plen_reg);
    assign idx_last = (({1'b0, idx} + 17'd1) == {1'b0, plen_reg});
    assign mp_m1    = mp_reg - 3'd1;

    // First-line scan of the payload.
    always_comb
    begin
        mp_next       = mp_reg;
        sc_next       = sc_reg;
        done_next     = done_reg;
        pend_next     = pend_reg;
        alive_next    = alive_reg;
        scan_stop     = 1'b0;
        scan_consumed = 1'b0;
        if (in_pay && !done_reg)
        begin
            if (idx < 16'd4)
            begin
                if (alive_reg && in_byte == tag_byte(idx[1:0]))
                begin
                    if (idx[1:0] == 2'd3)
                    begin
                        done_next = 1'b1;
                        pend_next = VERDICT_RESPONSE;
                        scan_stop = 1'b1;
                    end
                end
                else
                begin
                    alive_next = 1'b0;
                end
            end
            if (!scan_stop && mp_reg != 3'd0)
            begin
                if (in_byte == tag_byte(mp_m1[1:0]))
                begin
                    scan_consumed = 1'b1;
                    if (mp_reg == 3'd4)
                    begin
                        done_next = 1'b1;
                        pend_next = VERDICT_REQUEST;
                        scan_stop = 1'b1;
                    end
                    else
                    begin
                        mp_next = mp_reg + 3'd1;
                    end
                end
                else
                begin
                    mp_next = 3'd0;
                end
            end
            if (!scan_stop && !scan_consumed)
            begin
                if (in_byte < PRINT_LOW || in_byte > PRINT_HIGH)
                begin
                    done_next = 1'b1;
                    pend_next = VERDICT_NOT_HTTP;
                    scan_stop = 1'b1;
                end
                else if (in_byte == SPACE_CHAR && sc_reg != 2'd3)
                begin
                    sc_next = sc_reg + 2'd1;
                    // The second space opens the search for the version tag.
                    if (sc_reg == 2'd1)
                        mp_next = 3'd1;
                end
            end
            if (!scan_stop && idx_last)
            begin
                done_next = 1'b1;
                pend_next = VERDICT_NOT_HTTP;
            end
        end
    end

    // Verdict for a frame ending on this byte.
    assign ihl_eff = ihl_hit ? in_byte[3:0] : ihl_reg;
    assign ts_eff  = 7'd14 + {1'b0, ihl_eff, 2'b00};

    always_comb
    begin
        plen_out = 16'd0;
        if (o < ETH_HDR_BYTES)
            verdict = VERDICT_TRUNCATED;
        else if (ihl_eff < MIN_HDR_WORDS)
            verdict = VERDICT_BAD_IP_LEN;
        else if (o < {9'd0, ts_eff + 7'd12})
            verdict = VERDICT_TRUNCATED;
        else if (thw_next < MIN_HDR_WORDS)
            verdict = VERDICT_BAD_TCP_LEN;
        else
        begin
            plen_out = plen_next;
            if (plen_next == 16'd0)
                verdict = VERDICT_NO_PAYLOAD;
            else if (done_next)
                verdict = pend_next;
            else if (o == OFFSET_MAX)
                verdict = VERDICT_NOT_HTTP;
            else
                verdict = VERDICT_TRUNCATED;
        end
    end

    always_comb
    begin
        push_data.verdict        = verdict;
        push_data.http_number    = (verdict == VERDICT_REQUEST || verdict == VERDICT_RESPONSE) ?
                                   counter_reg : 16'd0;
        push_data.source_address = src_addr_next;
        push_data.dest_address   = dst_addr_next;
        push_data.source_port    = src_port_next;
        push_data.dest_port      = dst_port_next;
        push_data.payload_length = plen_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= 16'd0;
            ihl_reg         <= 4'd0;
            thw_reg         <= 4'd0;
            total_reg       <= 16'd0;
            src_addr_reg    <= 32'd0;
            dst_addr_reg    <= 32'd0;
            src_port_reg    <= 16'd0;
            dst_port_reg    <= 16'd0;
            mp_reg          <= 3'd0;
            sc_reg          <= 2'd0;
            done_reg        <= 1'b0;
            pend_reg        <= VERDICT_NOT_HTTP;
            alive_reg       <= 1'b1;
            counter_reg     <= 16'd1;
        end
        else if (take)
        begin
            if (in_last)
            begin
                byte_offset_reg <= 16'd0;
                ihl_reg         <= 4'd0;
                thw_reg         <= 4'd0;
                total_reg       <= 16'd0;
                src_addr_reg    <= 32'd0;
                dst_addr_reg    <= 32'd0;
                src_port_reg    <= 16'd0;
                dst_port_reg    <= 16'd0;
                mp_reg          <= 3'd0;
                sc_reg          <= 2'd0;
                done_reg        <= 1'b0;
                pend_reg        <= VERDICT_NOT_HTTP;
                alive_reg       <= 1'b1;
                if (verdict == VERDICT_REQUEST || verdict == VERDICT_RESPONSE)
                    counter_reg <= counter_reg + 16'd1;
            end
            else
            begin
                if (live)
                    byte_offset_reg <= o + 16'd1;
                ihl_reg      <= ihl_next;
                thw_reg      <= thw_next;
                total_reg    <= total_next;
                src_addr_reg <= src_addr_next;
                dst_addr_reg <= dst_addr_next;
                src_port_reg <= src_port_next;
                dst_port_reg <= dst_port_next;
                mp_reg       <= mp_next;
                sc_reg       <= sc_next;
                done_reg     <= done_next;
                pend_reg     <= pend_next;
                alive_reg    <= alive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ps_reg   <= ps_next;
            plen_reg <= plen_next;
        end
    end

    `HPC_ASSERT_NEXT(a_front_clear_after_end, take && in_last, byte_offset_reg == 16'd0 && !done_reg)
    `HPC_ASSERT(a_front_match_range, mp_reg <= 3'd4)
    `HPC_ASSERT(a_front_done_verdict, !done_reg || pend_reg <= VERDICT_NOT_HTTP)

endmodule

>>> rtl/hpc_queue.sv
`timescale 1ns / 1ps
`include "http_packet_classifier_core_macros.svh"
module hpc_queue
    import hpc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  result_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    result_t       entries_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    `HPC_ASSERT(a_queue_count_range, count_reg <= FULL_CNT)
    `HPC_ASSERT_NEXT(a_queue_count_up, do_push && !do_pop, count_reg == $past(count_reg) + CW'(1))

endmodule

>>> rtl/hpc_back.sv
`timescale 1ns / 1ps
`include "http_packet_classifier_core_macros.svh"
module hpc_back
    import hpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  result_t            q_data,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic               load;

    // The output register refills in the same cycle its transaction completes.
    assign q_ready       = !out_valid_reg || m_axis_tready;
    assign load          = q_valid && q_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_ready)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= {{(TDATA_W - RESULT_W){1'b0}}, q_data};
    end

    `HPC_ASSERT_NEXT(a_back_fill, q_valid && !out_valid_reg, out_valid_reg)

endmodule

>>> rtl/http_packet_classifier_core.sv
`timescale 1ns / 1ps
// Classifies Ethernet/IPv4/TCP frames as HTTP request, HTTP response or
// otherwise, one frame byte per transaction on the slave side with tlast on
// the frame's last byte, and gives one 136-bit result transaction per frame.
// Bytes are taken at one per clock unless the slave side stalls as described
// below; the parser updates its state in the cycle a byte arrives. The
// verdict of a frame enters a queue of QUEUE_DEPTH entries on its last byte
// and reaches the master side from that queue through the output register.
// The slave side stalls only while that queue is full, which happens when
// the master side holds back more than QUEUE_DEPTH results.
module http_packet_classifier_core
    import hpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tlast,   // frame_end
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // verdict, http_number, source_address, dest_address, source_port,
    // dest_port, payload_length, zero fill
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic    push_valid;
    logic    push_ready;
    result_t push_data;
    logic    pop_valid;
    logic    pop_ready;
    result_t pop_data;

    hpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hpc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (pop_valid),
        .q_ready       (pop_ready),
        .q_data        (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
